@@ rtl/core/moving_average_deviation_detector_unit_macros.svh @@
// Assertion macros used by the detector's checker.
`ifndef MOVING_AVERAGE_DEVIATION_DETECTOR_UNIT_MACROS_SVH
`define MOVING_AVERAGE_DEVIATION_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define MADD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define MADD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/madd_pkg.sv @@
// Types and constants of the moving average deviation detector.
package madd_pkg;

  localparam int WinLen    = 16;
  localparam int WinLog    = $clog2(WinLen);
  localparam int SmpW      = 16;
  localparam int SumW      = SmpW + WinLog;
  localparam int DevW      = SumW + 1;
  localparam int ThrW      = 15;
  localparam int HoldW     = 8;
  localparam int LimW      = ThrW + WinLog;
  localparam int CfgIdxW   = 1;
  localparam int CfgDataW  = 15;
  localparam int EvtW      = 2;
  localparam int OutTdataW = 8;

  localparam logic [ThrW-1:0]  ThrRst  = ThrW'(768);
  localparam logic [HoldW-1:0] HoldRst = HoldW'(30);

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold = 1'b0,
    CfgHoldoff   = 1'b1
  } cfg_idx_e;

  typedef enum logic [EvtW-1:0] {
    EvtNone    = 2'd0,
    EvtBump    = 2'd1,
    EvtPothole = 2'd2
  } evt_e;

  // One slot of the sample line: occupancy flag and sample.
  typedef struct packed {
    logic                   vld;
    logic signed [SmpW-1:0] data;
  } cell_t;

endpackage

@@ rtl/core/madd_cell.sv @@
// One slot of the sample delay line.
module madd_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  madd_pkg::cell_t d_i,
  output madd_pkg::cell_t q_o
);

  madd_pkg::cell_t cell_d, cell_q;

  always_comb begin
    cell_d = cell_q;
    if (en_i) begin
      cell_d = d_i;
    end
  end

  // ring resets to zero, so slots are cleared too
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign q_o = cell_q;

endmodule

@@ rtl/core/madd_eval.sv @@
// Deviation, threshold compare, hold-off and output register.
module madd_eval (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_vld_i,
  output logic                                in_rdy_o,
  input  logic signed [madd_pkg::SmpW-1:0]    in_smp_i,
  input  logic signed [madd_pkg::SumW-1:0]    in_sum_i,
  input  logic                                in_fill_i,
  input  logic        [madd_pkg::ThrW-1:0]    thr_i,
  input  logic        [madd_pkg::HoldW-1:0]   hold_len_i,
  output logic                                out_vld_o,
  input  logic                                out_rdy_i,
  output madd_pkg::evt_e                      out_evt_o
);

  localparam int DevW = madd_pkg::DevW;
  localparam int LimW = madd_pkg::LimW;
  localparam logic signed [DevW-1:0] WinMul = DevW'(madd_pkg::WinLen);

  logic                   p2_vld_d, p2_vld_q;
  logic signed [DevW-1:0] p2_dev_d, p2_dev_q;
  logic                   p2_fill_q;
  logic                   ovld_d, ovld_q;
  madd_pkg::evt_e         evt_d, evt_q;
  logic [madd_pkg::HoldW-1:0] hold_d, hold_q;

  logic                   out_rdy, p2_rdy, p2_adv;
  logic [LimW-1:0]        lim;
  logic signed [DevW-1:0] lim_s;
  logic                   hit_pos, hit_neg;

  assign out_rdy  = !ovld_q || out_rdy_i;
  assign p2_rdy   = !p2_vld_q || out_rdy;
  assign p2_adv   = p2_vld_q && out_rdy;
  assign in_rdy_o = p2_rdy;

  // N*sample - sum
  always_comb begin
    p2_dev_d = DevW'(in_smp_i) * WinMul - DevW'(in_sum_i);
    p2_vld_d = p2_vld_q;
    if (p2_rdy) begin
      p2_vld_d = in_vld_i;
    end
  end

  assign lim     = LimW'(thr_i) * LimW'(madd_pkg::WinLen);
  assign lim_s   = $signed(DevW'(lim));
  assign hit_pos = p2_dev_q > lim_s;
  assign hit_neg = p2_dev_q < -lim_s;

  always_comb begin
    hold_d = hold_q;
    evt_d  = evt_q;
    ovld_d = ovld_q;
    if (out_rdy) begin
      ovld_d = p2_vld_q;
    end
    if (p2_adv) begin
      evt_d = madd_pkg::EvtNone;
      if (!p2_fill_q) begin
        evt_d = madd_pkg::EvtNone;
      end else if (hold_q != '0) begin
        hold_d = hold_q - 1'b1;
      end else if (hit_pos) begin
        evt_d  = madd_pkg::EvtBump;
        hold_d = hold_len_i;
      end else if (hit_neg) begin
        evt_d  = madd_pkg::EvtPothole;
        hold_d = hold_len_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_vld_q <= 1'b0;
      ovld_q   <= 1'b0;
      hold_q   <= '0;
    end else begin
      p2_vld_q <= p2_vld_d;
      ovld_q   <= ovld_d;
      hold_q   <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_rdy && in_vld_i) begin
      p2_dev_q  <= p2_dev_d;
      p2_fill_q <= in_fill_i;
    end
    evt_q <= evt_d;
  end

  assign out_vld_o = ovld_q;
  assign out_evt_o = evt_q;

endmodule

@@ rtl/core/moving_average_deviation_detector_unit.sv @@
// Moving average deviation detector: sample line, running sum, front stage.
//
// Takes one signed Q8.8 acceleration sample per beat and returns one event
// code per sample (0 none, 1 bump, 2 pothole), in order. The last WinLen
// samples sit in a line of WinLen cells that all shift on each accepted
// beat; the cell at the far end holds the oldest sample, which leaves the
// running sum as the new one enters. Each cell carries an occupancy flag,
// and the window counts as filled once that flag reaches the last cell.
// Nothing is reported before that; the filling sample itself is judged.
// A sample is judged by comparing |WinLen*sample - sum| against
// WinLen*threshold (strictly greater), and a hit loads the hold-off
// counter, which then blanks that many samples.
// Rate: one beat per cycle while m_axis takes results. Stages, in order from
// input beat to output valid: sum update, deviation, compare/hold-off. Each stage
// has its own ready, so new beats enter while a result waits on m_axis.
// Reset clears every cell at once; no clearing pass is needed.
// Registers: index 0 deviation threshold (15 bits, reset 768 = 3.0),
// index 1 hold-off length (8 bits, reset 30). Write only while idle.
module moving_average_deviation_detector_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [madd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [madd_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [madd_pkg::SmpW-1:0]          s_axis_tdata,  // [15:0] accel_sample
  // output stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [madd_pkg::OutTdataW-1:0]     m_axis_tdata   // [1:0] event_class, rest 0
);

  localparam int WinLen = madd_pkg::WinLen;
  localparam int SumW   = madd_pkg::SumW;
  localparam int SmpW   = madd_pkg::SmpW;

  // config registers
  logic [madd_pkg::ThrW-1:0]  thr_d, thr_q;
  logic [madd_pkg::HoldW-1:0] hold_len_d, hold_len_q;

  always_comb begin
    thr_d      = thr_q;
    hold_len_d = hold_len_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        madd_pkg::CfgThreshold: thr_d      = cfg_wdata_i[madd_pkg::ThrW-1:0];
        madd_pkg::CfgHoldoff:   hold_len_d = cfg_wdata_i[madd_pkg::HoldW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= madd_pkg::ThrRst;
      hold_len_q <= madd_pkg::HoldRst;
    end else begin
      thr_q      <= thr_d;
      hold_len_q <= hold_len_d;
    end
  end

  // front stage: sample, updated sum, filled flag
  logic                   p1_vld_d, p1_vld_q;
  logic signed [SmpW-1:0] p1_smp_q;
  logic signed [SumW-1:0] p1_sum_q;
  logic                   p1_fill_q;

  // handshake
  logic accept;
  logic p1_rdy;
  logic eval_rdy;

  assign p1_rdy        = !p1_vld_q || eval_rdy;
  assign s_axis_tready = p1_rdy;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // sample line: chain[0] is the new sample, chain[WinLen] the oldest
  madd_pkg::cell_t chain [WinLen+1];

  assign chain[0] = '{vld: 1'b1, data: $signed(s_axis_tdata)};

  for (genvar k = 0; k < WinLen; k++) begin : g_cell
    madd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept),
      .d_i    (chain[k]),
      .q_o    (chain[k+1])
    );
  end

  // running sum, exact at SumW bits
  logic signed [SumW-1:0] sum_d, sum_q;

  always_comb begin
    sum_d = sum_q;
    if (accept) begin
      sum_d = sum_q - SumW'(chain[WinLen].data) + SumW'(chain[0].data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  always_comb begin
    p1_vld_d = p1_vld_q;
    if (p1_rdy) begin
      p1_vld_d = accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
    end else begin
      p1_vld_q <= p1_vld_d;
    end
  end

  // filled once the flag moves into the last cell on this beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      p1_smp_q  <= chain[0].data;
      p1_sum_q  <= sum_d;
      p1_fill_q <= chain[WinLen-1].vld;
    end
  end

  madd_pkg::evt_e evt;

  madd_eval u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (p1_vld_q),
    .in_rdy_o   (eval_rdy),
    .in_smp_i   (p1_smp_q),
    .in_sum_i   (p1_sum_q),
    .in_fill_i  (p1_fill_q),
    .thr_i      (thr_q),
    .hold_len_i (hold_len_q),
    .out_vld_o  (m_axis_tvalid),
    .out_rdy_i  (m_axis_tready),
    .out_evt_o  (evt)
  );

  assign m_axis_tdata = madd_pkg::OutTdataW'(evt);

endmodule

@@ rtl/core/madd_checker.sv @@
// Port-level checks of the detector, bound to the top level.
`include "moving_average_deviation_detector_unit_macros.svh"

module madd_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [madd_pkg::OutTdataW-1:0]     m_axis_tdata
);

  logic in_beat;
  logic out_stall;

  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // only codes none, bump, pothole; pad bits zero
  `MADD_ASSERT_IMP(a_code_legal, m_axis_tvalid, m_axis_tdata < 8'd3, "illegal event code")

  // an output that appears from empty came from an earlier input beat
  `MADD_ASSERT_IMP(a_latency, $rose(m_axis_tvalid), $past(in_beat, 3), "result without input beat")

  // input stalls only when the whole pipe is backed up
  `MADD_ASSERT_IMP(a_stall_full, !s_axis_tready, m_axis_tvalid, "input stalled, output empty")

  // stalled result holds
  `MADD_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata), "output changed")

endmodule

bind moving_average_deviation_detector_unit madd_checker u_madd_checker (.*);

@@ dv/moving_average_deviation_detector_unit_test.sv @@
// Self-checking testbench for the moving average deviation detector.
module moving_average_deviation_detector_unit_test;
  import madd_pkg::*;

  localparam int PipeLat      = 3;          // input beat to output valid
  localparam int RoadBase     = 2511;       // about 1 g in Q8.8
  localparam int TimeoutTicks = 2_000_000;  // far beyond the slowest legal run
  localparam int NumDirRows   = 17;

  typedef enum logic {
    RowSample = 1'b0,
    RowConfig = 1'b1
  } row_kind_e;

  // One line of the directed table. A config row loads both registers;
  // a sample row sends smp reps times. pinned rows carry a hand-written
  // event, all others go to the predictor.
  typedef struct packed {
    row_kind_e        kind;
    logic [SmpW-1:0]  smp;
    logic [ThrW-1:0]  thr;
    logic [HoldW-1:0] hold;
    logic [7:0]       reps;
    logic             pinned;
    evt_e             evt;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [SmpW-1:0]      s_axis_tdata;   // [15:0] accel_sample
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;   // [1:0] event_class, [7:2] zero

  // Hand-written expectation that travels with the beat on s_axis.
  logic pin_valid;
  evt_e pin_evt;

  // Detector state as the predictor sees it.
  logic signed [SmpW-1:0] ring_q [WinLen];
  logic signed [SumW-1:0] run_sum;
  logic [WinLog-1:0]      wr_pos;
  logic                   ring_full;
  logic [HoldW-1:0]       blank_cnt;
  logic [ThrW-1:0]        cur_thr;
  logic [HoldW-1:0]       cur_hold;

  evt_e pending_evt_q[$];

  int src_idle_pct;
  int sink_idle_pct;
  int n_err;
  int n_in;
  int n_cfg;
  int n_bump;
  int n_pothole;

  // Directed part. Extremes first while the window is still filling, then
  // the fill sample, hold-off, zero threshold / zero hold-off, a deviation
  // exactly on the limit, and the largest threshold with the largest hold-off.
  dir_row_t dir_tab [NumDirRows] = '{
    '{RowConfig, 16'h0000, 15'd15,    8'd1,   8'd0,  1'b0, EvtNone},
    '{RowSample, 16'h7FFF, 15'd0,     8'd0,   8'd1,  1'b1, EvtNone},  // not filled
    '{RowSample, 16'h8000, 15'd0,     8'd0,   8'd1,  1'b1, EvtNone},
    '{RowSample, 16'hFFFF, 15'd0,     8'd0,   8'd1,  1'b1, EvtNone},
    '{RowSample, 16'h0001, 15'd0,     8'd0,   8'd1,  1'b1, EvtNone},
    '{RowSample, 16'h0000, 15'd0,     8'd0,   8'd11, 1'b1, EvtNone},
    '{RowSample, 16'h0000, 15'd0,     8'd0,   8'd1,  1'b0, EvtNone},  // fill sample judged
    '{RowSample, 16'h7FFF, 15'd0,     8'd0,   8'd1,  1'b0, EvtNone},  // big bump
    '{RowSample, 16'h8000, 15'd0,     8'd0,   8'd1,  1'b1, EvtNone},  // blanked
    '{RowSample, 16'h8000, 15'd0,     8'd0,   8'd1,  1'b0, EvtNone},  // pothole
    '{RowSample, 16'h0000, 15'd0,     8'd0,   8'd1,  1'b1, EvtNone},  // blanked
    '{RowConfig, 16'h0000, 15'd0,     8'd0,   8'd0,  1'b0, EvtNone},
    '{RowSample, 16'h0000, 15'd0,     8'd0,   8'd2,  1'b0, EvtNone},  // back to back hits
    '{RowConfig, 16'h0000, 15'd2049,  8'd0,   8'd0,  1'b0, EvtNone},
    '{RowSample, 16'h0001, 15'd0,     8'd0,   8'd1,  1'b0, EvtNone},  // dev == limit
    '{RowConfig, 16'h0000, 15'd32767, 8'd255, 8'd0,  1'b0, EvtNone},
    '{RowSample, 16'h8000, 15'd0,     8'd0,   8'd1,  1'b0, EvtNone}
  };

  moving_average_deviation_detector_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(TimeoutTicks);
    $display("moving_average_deviation_detector_unit verification failed");
    $finish;
  end

  // Receiver backpressure, redrawn every cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Predictor: shift one sample into the window and classify it.
  // Exact integer compare, |16*s - sum| > 16*thr, no division.
  function automatic evt_e classify_sample(logic signed [SmpW-1:0] smp);
    logic signed [DevW-1:0] dev;
    logic signed [DevW-1:0] mag;
    logic signed [DevW-1:0] lim;
    evt_e                   cls;
    run_sum = run_sum - ring_q[wr_pos] + smp;
    ring_q[wr_pos] = smp;
    if (wr_pos == WinLog'(WinLen - 1)) begin
      ring_full = 1'b1;
    end
    wr_pos = wr_pos + 1'b1;
    cls = EvtNone;
    if (!ring_full) begin
      return cls;
    end
    if (blank_cnt != '0) begin
      blank_cnt = blank_cnt - 1'b1;
      return cls;
    end
    dev = smp;
    dev = (dev <<< WinLog) - run_sum;
    mag = (dev < 0) ? -dev : dev;
    lim = {cur_thr, {WinLog{1'b0}}};
    if (mag > lim) begin
      blank_cnt = cur_hold;
      cls = (dev > 0) ? EvtBump : EvtPothole;
    end
    return cls;
  endfunction

  // Scoreboard: predict on every input beat, check on every output beat.
  always @(posedge clk_i) begin : scoreboard
    evt_e want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        want = classify_sample(s_axis_tdata);
        if (pin_valid) begin
          want = pin_evt;
        end
        pending_evt_q.push_back(want);
        n_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_evt_q.size() == 0) begin
          $error("event_class: no result expected, actual %0d", m_axis_tdata[EvtW-1:0]);
          n_err++;
        end else begin
          want = pending_evt_q.pop_front();
          if (m_axis_tdata[EvtW-1:0] !== want) begin
            $error("event_class: expected %0d, actual %0d", want, m_axis_tdata[EvtW-1:0]);
            n_err++;
          end
          if (m_axis_tdata[OutTdataW-1:EvtW] !== '0) begin
            $error("tdata pad: expected 0, actual %0h", m_axis_tdata[OutTdataW-1:EvtW]);
            n_err++;
          end
          if (want == EvtBump) n_bump++;
          if (want == EvtPothole) n_pothole++;
        end
      end
    end
  end

  // Send one beat. tvalid stays high into the next call unless a gap is
  // drawn, so it never gets two updates in one step.
  task automatic push_sample(logic [SmpW-1:0] smp, logic pinned, evt_e evt);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    pin_valid     <= pinned;
    pin_evt       <= evt;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_evt_q.size() != 0) @(posedge clk_i);
    repeat (PipeLat + 2) @(posedge clk_i);
  endtask

  // Write both registers; only called with the pipe empty.
  task automatic load_regs(logic [ThrW-1:0] thr, logic [HoldW-1:0] hold);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgThreshold;
    cfg_wdata_i <= CfgDataW'(thr);
    @(posedge clk_i);
    cfg_idx_i   <= CfgHoldoff;
    cfg_wdata_i <= CfgDataW'(hold);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    cur_thr  = thr;
    cur_hold = hold;
    n_cfg++;
  endtask

  initial begin
    int               pick;
    int               smp_v;
    logic [ThrW-1:0]  thr_v;
    logic [HoldW-1:0] hold_v;

    // every input known from time zero
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgThreshold;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    pin_valid     = 1'b0;
    pin_evt       = EvtNone;
    src_idle_pct  = 24;
    sink_idle_pct = 65;
    n_err = 0; n_in = 0; n_cfg = 0; n_bump = 0; n_pothole = 0;

    // predictor starts from the reset state
    foreach (ring_q[i]) ring_q[i] = '0;
    run_sum   = '0;
    wr_pos    = '0;
    ring_full = 1'b0;
    blank_cnt = '0;
    cur_thr   = ThrRst;
    cur_hold  = HoldRst;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowConfig) begin
        wait_idle();
        load_regs(dir_tab[i].thr, dir_tab[i].hold);
      end else begin
        for (int r = 0; r < dir_tab[i].reps; r++) begin
          push_sample(dir_tab[i].smp, dir_tab[i].pinned, dir_tab[i].evt);
        end
      end
    end

    // random part: three idle regimes, four register settings each
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin src_idle_pct = 24; sink_idle_pct = 65; end
        1: begin src_idle_pct = 65; sink_idle_pct = 24; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      for (int seg = 0; seg < 4; seg++) begin
        case ((regime * 4 + seg) % 6)
          0: begin thr_v = ThrRst; hold_v = HoldRst; end
          1: begin thr_v = '0; hold_v = '0; end
          2: begin thr_v = '1; hold_v = '1; end
          3: begin thr_v = ThrW'($urandom_range(1500)); hold_v = HoldW'($urandom_range(6)); end
          4: begin thr_v = ThrW'($urandom); hold_v = HoldW'($urandom); end
          default: begin
            thr_v  = ThrW'($urandom_range(64));
            hold_v = HoldW'($urandom_range(3));
          end
        endcase
        wait_idle();
        load_regs(thr_v, hold_v);
        for (int k = 0; k < 50; k++) begin
          // mostly a quiet road near 1 g, some bumps and dips, some raw noise
          pick = $urandom_range(99);
          if (pick < 70) begin
            smp_v = RoadBase + int'($urandom_range(600)) - 300;
          end else if (pick < 90) begin
            smp_v = int'($urandom_range(8000, 400));
            if ($urandom_range(1)) smp_v = -smp_v;
            smp_v = smp_v + RoadBase;
          end else begin
            smp_v = int'($urandom);
          end
          push_sample(smp_v[SmpW-1:0], 1'b0, EvtNone);
          // sender holds off mid-segment until the pipe drains
          if (seg == 1 && k == 25) wait_idle();
        end
      end
    end

    wait_idle();

    $display("Sent %0d samples under %0d register settings and three idle regimes.",
             n_in, n_cfg);
    $display("Saw %0d bumps and %0d potholes.", n_bump, n_pothole);
    if (n_err == 0) begin
      $display("moving_average_deviation_detector_unit verification clean");
    end else begin
      $display("moving_average_deviation_detector_unit verification failed");
    end
    $finish;
  end

endmodule
